// ----- design/gcbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid cell bucket mover package
// Shared types, sizes and codes for the grid binning block.
// ----------------------------------------------------------------------------
package gcbm_pkg;

  localparam int MaxObjects = 1024;
  localparam int MaxCells   = 4096;
  localparam int IdW        = $clog2(MaxObjects);
  localparam int CellW      = $clog2(MaxCells);
  localparam int LinkW      = 11;
  localparam logic [LinkW-1:0] LinkEmpty = 11'd2047;

  localparam logic [1:0] CfgCellSide    = 2'd0;
  localparam logic [1:0] CfgWorldWidth  = 2'd1;
  localparam logic [1:0] CfgWorldLength = 2'd2;
  localparam logic [1:0] CfgCellsAcross = 2'd3;

  localparam logic [2:0] StSame   = 3'd0;
  localparam logic [2:0] StMoved  = 3'd1;
  localparam logic [2:0] StFirst  = 3'd2;
  localparam logic [2:0] StOutside = 3'd3;
  localparam logic [2:0] StBeyond = 3'd4;

  typedef struct packed {
    logic [9:0]         object_id;
    logic signed [23:0] x_pos;
    logic signed [23:0] y_pos;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] cell_index;
  } out_item_t;

  // Classified move handed from front to back.
  typedef struct packed {
    logic             reject;
    logic [2:0]       status;
    logic [IdW-1:0]   id;
    logic [CellW-1:0] cell_idx;
  } move_t;

endpackage

// ----- design/grid_cell_bucket_mover_top.sv -----
// ----------------------------------------------------------------------------
// Grid cell bucket mover
// Bins object positions into a uniform grid and keeps a linked list per cell.
// ----------------------------------------------------------------------------
// Each in_ beat moves one object to a signed Q16.8 position; each out_ beat
// gives one status and cell index, in input order. The front end checks the
// world bounds and divides both coordinates by the cell side on one restoring
// divider at one bit per cycle, or skips it for a position outside the world;
// it takes a new item only once it has handed the last one to the two-entry
// queue, which hands the move to the back end that updates the cell lists.
// After reset the back end clears the 4096-entry head table and the placed
// flags, one entry a cycle, before it gives results; inputs are still taken
// meanwhile until the queue fills. A stalled receiver holds the output
// register, then the queue, then in_ready.
// Configuration writes take effect at once; write only while idle.
// ----------------------------------------------------------------------------
module grid_cell_bucket_mover_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gcbm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import gcbm_pkg::*;

  logic [15:0] side_r, width_r, length_r;
  logic [12:0] across_r;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  move_t       fq_data, qb_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= 16'd16;
      width_r  <= 16'd1024;
      length_r <= 16'd1024;
      across_r <= 13'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgCellSide:    side_r   <= cfg_wdata;
        CfgWorldWidth:  width_r  <= cfg_wdata;
        CfgWorldLength: length_r <= cfg_wdata;
        CfgCellsAcross: across_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  gcbm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cell_side(side_r), .world_width(width_r), .world_length(length_r),
    .cells_across(across_r),
    .mv_valid(fq_valid), .mv_ready(fq_ready), .mv_data(fq_data)
  );

  gcbm_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  gcbm_back u_back (
    .clk, .rst_n,
    .mv_valid(qb_valid), .mv_ready(qb_ready), .mv_data(qb_data),
    .out_valid, .out_ready, .out_data
  );

endmodule

// ----- design/gcbm_front.sv -----
// ----------------------------------------------------------------------------
// Grid cell bucket mover front end
// Checks world bounds, divides both coordinates by the cell side with a
// shared restoring divider and forms the cell index.
// ----------------------------------------------------------------------------
module gcbm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gcbm_pkg::in_item_t in_data,
  input  logic [15:0]        cell_side,
  input  logic [15:0]        world_width,
  input  logic [15:0]        world_length,
  input  logic [12:0]        cells_across,
  output logic               mv_valid,
  input  logic               mv_ready,
  output gcbm_pkg::move_t    mv_data
);
  import gcbm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIVX, S_DIVY, S_MUL, S_SUM, S_OUT} state_t;

  state_t         state_r;
  logic [IdW-1:0] id_r;
  logic [15:0]    side_r, quo_r, rem_r, dvd_r, cx_r, ylo_r;
  logic [3:0]     cnt_r;
  logic [28:0]    prod_r;
  move_t          mv_r;

  logic [16:0] trial;
  logic        x_bad, y_bad;
  logic [15:0] side_eff;
  logic [29:0] cell_sum;

  assign trial    = {rem_r, dvd_r[15]} - {1'b0, side_r};
  assign x_bad    = in_data.x_pos[23] || (in_data.x_pos[23:8] >= world_width);
  assign y_bad    = in_data.y_pos[23] || (in_data.y_pos[23:8] >= world_length);
  assign side_eff = (cell_side == 16'd0) ? 16'd1 : cell_side;
  assign cell_sum = {1'b0, prod_r} + {14'd0, cx_r};
  assign in_ready = (state_r == S_IDLE);
  assign mv_valid = (state_r == S_OUT);
  assign mv_data  = mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            id_r   <= in_data.object_id[IdW-1:0];
            side_r <= side_eff;
            dvd_r  <= in_data.x_pos[23:8];
            ylo_r  <= in_data.y_pos[23:8];
            rem_r  <= '0;
            cnt_r  <= '0;
            if (x_bad || y_bad) begin
              mv_r    <= '{reject: 1'b1, status: StOutside, id: '0, cell_idx: '0};
              state_r <= S_OUT;
            end else begin
              state_r <= S_DIVX;
            end
          end
        end
        S_DIVX, S_DIVY: begin
          // One quotient bit per cycle.
          if (trial[16]) begin
            rem_r <= {rem_r[14:0], dvd_r[15]};
            quo_r <= {quo_r[14:0], 1'b0};
          end else begin
            rem_r <= trial[15:0];
            quo_r <= {quo_r[14:0], 1'b1};
          end
          dvd_r <= {dvd_r[14:0], 1'b0};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            if (state_r == S_DIVX) begin
              cx_r    <= {quo_r[14:0], ~trial[16]};
              dvd_r   <= ylo_r;
              rem_r   <= '0;
              state_r <= S_DIVY;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= quo_r * cells_across;
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (cell_sum >= 30'(MaxCells)) begin
            mv_r <= '{reject: 1'b1, status: StBeyond, id: '0, cell_idx: '0};
          end else begin
            mv_r <= '{reject: 1'b0, status: StSame, id: id_r,
                      cell_idx: cell_sum[CellW-1:0]};
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (mv_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/gcbm_queue.sv -----
// ----------------------------------------------------------------------------
// Grid cell bucket mover queue
// Two-entry queue that decouples the front end from the list updater.
// ----------------------------------------------------------------------------
module gcbm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  gcbm_pkg::move_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output gcbm_pkg::move_t rd_data
);
  import gcbm_pkg::*;

  move_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ----- design/gcbm_back.sv -----
// ----------------------------------------------------------------------------
// Grid cell bucket mover back end
// Unlinks a moved object from its old cell list, pushes a moved or new object
// at the head of its cell list and presents the result in an output register.
// ----------------------------------------------------------------------------
module gcbm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mv_valid,
  output logic                mv_ready,
  input  gcbm_pkg::move_t     mv_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gcbm_pkg::out_item_t out_data
);
  import gcbm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHK, S_UNL, S_HEADRD, S_HEADWT, S_PUSH, S_DONE
  } state_t;

  logic [LinkW-1:0] head_mem [MaxCells];
  logic [LinkW-1:0] next_mem [MaxObjects];
  logic [LinkW-1:0] prev_mem [MaxObjects];
  logic [CellW-1:0] cell_mem [MaxObjects];
  logic             placed_mem [MaxObjects];

  state_t           state_r;
  logic [CellW:0]   clr_r;
  move_t            mv_r;
  logic [LinkW-1:0] nxt_r, prv_r, hd_r, head_q;
  logic [CellW-1:0] old_r;
  logic             was_r;
  logic [2:0]       status_r;
  out_item_t        out_r;
  logic             out_valid_r;

  logic nxt_ok, prv_ok, hd_ok;
  assign nxt_ok = nxt_r < LinkW'(MaxObjects);
  assign prv_ok = prv_r < LinkW'(MaxObjects);
  assign hd_ok  = hd_r  < LinkW'(MaxObjects);

  assign mv_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Head memory: one read port with registered data, writes from the sequencer.
  always_ff @(posedge clk) begin
    head_q <= head_mem[mv_r.cell_idx];
    if (state_r == S_CLEAR) begin
      head_mem[clr_r[CellW-1:0]] <= LinkEmpty;
    end else if (state_r == S_UNL && !prv_ok) begin
      head_mem[old_r] <= nxt_ok ? nxt_r : LinkEmpty;
    end else if (state_r == S_PUSH) begin
      head_mem[mv_r.cell_idx] <= LinkW'(mv_r.id);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      nxt_r <= next_mem[mv_r.id];
      prv_r <= prev_mem[mv_r.id];
      old_r <= cell_mem[mv_r.id];
      was_r <= placed_mem[mv_r.id];
    end
    // The placed flags are cleared during the same pass as the head table.
    if (state_r == S_CLEAR) begin
      placed_mem[clr_r[IdW-1:0]] <= 1'b0;
    end
    if (state_r == S_UNL) begin
      if (nxt_ok) prev_mem[nxt_r[IdW-1:0]] <= prv_r;
      if (prv_ok) next_mem[prv_r[IdW-1:0]] <= nxt_r;
    end
    if (state_r == S_PUSH) begin
      next_mem[mv_r.id]   <= hd_ok ? hd_r : LinkEmpty;
      cell_mem[mv_r.id]   <= mv_r.cell_idx;
      placed_mem[mv_r.id] <= 1'b1;
      prev_mem[mv_r.id]   <= LinkEmpty;
      if (hd_ok) prev_mem[hd_r[IdW-1:0]] <= LinkW'(mv_r.id);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (CellW+1)'(MaxCells - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (mv_valid && !out_valid_r) begin
            mv_r <= mv_data;
            if (mv_data.reject) begin
              out_r       <= '{status: mv_data.status, cell_index: '0};
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (was_r && old_r == mv_r.cell_idx) begin
            status_r <= StSame;
            state_r  <= S_DONE;
          end else if (was_r) begin
            status_r <= StMoved;
            state_r  <= S_UNL;
          end else begin
            status_r <= StFirst;
            state_r  <= S_HEADRD;
          end
        end
        S_UNL:    state_r <= S_HEADRD;
        S_HEADRD: state_r <= S_HEADWT;
        S_HEADWT: begin
          hd_r    <= head_q;
          state_r <= S_PUSH;
        end
        S_PUSH: state_r <= S_DONE;
        S_DONE: begin
          out_r       <= '{status: status_r, cell_index: 12'(mv_r.cell_idx)};
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
